@@ rtl/osm_pkg.sv @@
// ----------------------------------------------------------------------------
// osm_pkg
// shared types and codes of the order statistic multiset
// ----------------------------------------------------------------------------
package osm_pkg;

   localparam int VALUE_W = 31;
   localparam int RANK_W  = 8;

   // operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef struct packed {
      logic               func;
      logic [VALUE_W-1:0] value;
      logic [RANK_W-1:0]  rank;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] kth_value;
      logic               rank_valid;
      logic               insert_dropped;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch rank and drop flag of the accepted item
      logic insert_en;   // shift the cells open and place the value
      logic remove_en;   // close the gap over one copy of the value
      logic drop_flag;   // insert refused, store full
      logic select;      // register the cell at the requested rank
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
   } sts_type;

endpackage

@@ rtl/osm_ctrl.sv @@
// ----------------------------------------------------------------------------
// osm_ctrl
// two-state sequencer: update cycle on accept, then rank select cycle
// ----------------------------------------------------------------------------
module osm_ctrl
   import osm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    func,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_strobe
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SELECT = 1'b1;

   logic state_ff;
   logic state_in;
   logic strobe_ff;
   logic accept;

   assign busy   = (state_ff == ST_SELECT);
   assign accept = start && !busy;

   always_comb begin
      cmd.capture   = accept;
      cmd.insert_en = accept && (func == FUNC_INSERT) && !sts.full;
      cmd.remove_en = accept && (func == FUNC_REMOVE);
      cmd.drop_flag = (func == FUNC_INSERT) && sts.full;
      cmd.select    = (state_ff == ST_SELECT);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SELECT;
         end
         ST_SELECT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.select;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

@@ rtl/osm_datapath.sv @@
// ----------------------------------------------------------------------------
// osm_datapath
// chain of sorted cells with element count and rank select register
// ----------------------------------------------------------------------------
module osm_datapath
   import osm_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic [VALUE_W-1:0] value,
   input  logic [RANK_W-1:0]  rank,
   output sts_type            sts,
   output rsp_type            rsp
);

   localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

   logic [VALUE_W-1:0] cell_ff [CAPACITY];
   logic [VALUE_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0] le;
   logic [CAPACITY-1:0] lt;
   logic [CAPACITY-1:0] eq;
   logic                found;
   logic                shift_en;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;
   logic [RANK_W-1:0]   rank_ff;
   logic                drop_ff;
   logic                rank_ok;
   rsp_type             rsp_ff;

   // per cell compares against the incoming value, occupied cells only
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (CW'(i) < count_ff) && (cell_ff[i] <= value);
         lt[i] = (CW'(i) < count_ff) && (cell_ff[i] <  value);
         eq[i] = (CW'(i) < count_ff) && (cell_ff[i] == value);
      end
   end

   assign found    = |eq;
   assign shift_en = cmd.insert_en || (cmd.remove_en && found);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic prev_le;
         logic [VALUE_W-1:0] prev_val;
         logic [VALUE_W-1:0] next_val;

         if (g == 0) begin : g_first
            assign prev_le  = 1'b1;
            assign prev_val = value;
         end else begin : g_rest
            assign prev_le  = le[g-1];
            assign prev_val = cell_ff[g-1];
         end

         if (g == CAPACITY - 1) begin : g_last
            assign next_val = cell_ff[g];
         end else begin : g_mid
            assign next_val = cell_ff[g+1];
         end

         always_comb begin
            if (cmd.insert_en) begin
               if (le[g])        cell_in[g] = cell_ff[g];
               else if (prev_le) cell_in[g] = value;
               else              cell_in[g] = prev_val;
            end else begin
               if (lt[g]) cell_in[g] = cell_ff[g];
               else       cell_in[g] = next_val;
            end
         end

         always_ff @(posedge clock) begin
            if (shift_en) cell_ff[g] <= cell_in[g];
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en)               count_in = count_ff + CW'(1);
      else if (cmd.remove_en && found) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign sts.full = (count_ff == CW'(CAPACITY));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rank_ff <= rank;
         drop_ff <= cmd.drop_flag;
      end
   end

   assign rank_ok = (CMPW'(rank_ff) < CMPW'(count_ff));

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         rsp_ff.kth_value      <= rank_ok ? cell_ff[IW'(rank_ff)] : '0;
         rsp_ff.rank_valid     <= rank_ok;
         rsp_ff.insert_dropped <= drop_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

@@ rtl/order_statistic_multiset.sv @@
// ----------------------------------------------------------------------------
// order_statistic_multiset
// bounded sorted multiset with insert, remove-one and k-th smallest query
// ----------------------------------------------------------------------------
// result strobe: registered from the select state that the accept enters
// one item at a time: the cell chain shifts on the accepting edge, then the
//   select state registers the cell at the requested rank
// busy is high for the single select cycle; results cannot be stalled
// synchronous reset empties the store (count to zero); cell contents are
//   left as they are and never read before being written
module order_statistic_multiset
   import osm_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   // command and status between sequencer and cell chain
   cmd_type cmd;
   sts_type sts;

   // sequencer: on accept the cell chain updates straight from the item
   // ports, the following cycle selects the requested rank
   osm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_data.func),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // sorted cells: every cell compares with the value in parallel, then
   // shifts up (insert after equal copies) or down (remove first copy)
   osm_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .value (req_data.value),
      .rank  (req_data.rank),
      .sts   (sts),
      .rsp   (rsp_data)
   );

   // every accepted item gives its result strobe, registered from its select cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result strobe missing after accepted item");

   // the select cycle lasts one cycle only
   assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held for more than one cycle");

   // a result goes out only once the block is idle again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   // a rank at or beyond the count reports zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.rank_valid) |-> (rsp_data.kth_value == '0))
      else $error("invalid rank with nonzero value");

endmodule

@@ tb/tb_order_statistic_multiset.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_order_statistic_multiset
// self-checking bench for the bounded sorted multiset with k-th query.
// Items go in through the start/busy handshake in random bursts. A scoreboard
// keeps its own sorted copy of the contents, predicts the answer to every
// accepted item and checks each strobed result in order against it.
// ----------------------------------------------------------------------------
module tb_order_statistic_multiset
   import osm_pkg::*;
();

   localparam int CAPACITY   = 256;
   localparam int VALUE_MAX  = 32'h7fff_ffff;
   localparam int RANK_MAX   = 255;
   localparam int TAIL_WAIT  = 8;

   // -------------------------------------------------------------------------
   // scoreboard: sorted shadow of the multiset and the answers still due
   // -------------------------------------------------------------------------
   class kth_scoreboard;
      int                 capacity;
      logic [VALUE_W-1:0] shadow_sorted[$];
      rsp_type            answers_due[$];
      int                 fail_count;

      function new(int cap);
         capacity   = cap;
         fail_count = 0;
      endfunction

      // apply one accepted item to the shadow and queue the answer it produces
      function void note_request(req_type r);
         rsp_type ans;
         int      pos;
         ans = '0;
         pos = 0;
         if (r.func == FUNC_INSERT) begin
            if (shadow_sorted.size() >= capacity) begin
               ans.insert_dropped = 1'b1;
            end else begin
               // new copy goes after every equal copy
               while (pos < shadow_sorted.size() && shadow_sorted[pos] <= r.value) pos++;
               shadow_sorted.insert(pos, r.value);
            end
         end else begin
            while (pos < shadow_sorted.size() && shadow_sorted[pos] < r.value) pos++;
            if (pos < shadow_sorted.size() && shadow_sorted[pos] == r.value)
               shadow_sorted.delete(pos);
         end
         if (int'(r.rank) < shadow_sorted.size()) begin
            ans.kth_value  = shadow_sorted[r.rank];
            ans.rank_valid = 1'b1;
         end
         answers_due.push_back(ans);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s: want kth=%0d valid=%b dropped=%b, got kth=%0d valid=%b dropped=%b",
                     $realtime, what, want.kth_value, want.rank_valid, want.insert_dropped,
                     got.kth_value, got.rank_valid, got.insert_dropped);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (answers_due.size() == 0) begin
            report("result with nothing outstanding", '0, got);
            return;
         end
         want = answers_due.pop_front();
         if (got.kth_value !== want.kth_value || got.rank_valid !== want.rank_valid ||
             got.insert_dropped !== want.insert_dropped)
            report("result mismatch", want, got);
      endfunction

      function int outstanding();
         return answers_due.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset, dut
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   kth_scoreboard sb;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   order_statistic_multiset #(
      .CAPACITY (CAPACITY)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // -------------------------------------------------------------------------
   // monitor: values read here are the ones present before the edge
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe)     sb.check_result(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // stimulus side
   // -------------------------------------------------------------------------
   // values believed to be stored, used only to aim removals and ranks
   int unsigned live_pool[$];
   int          burst_left;

   // hold one item on the port until an edge with busy low takes it;
   // busy only moves at rising edges so the falling edge shows its value
   task automatic send_item(input req_type r);
      logic was_busy;
      req_data <= r;
      start    <= 1'b1;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
   endtask

   // bursts of random length, random gaps between them (often none)
   task automatic issue(input logic f, input int unsigned v, input int unsigned rk);
      req_type r;
      int      gap;
      int      idx;
      r.func  = f;
      r.value = v[VALUE_W-1:0];
      r.rank  = rk[RANK_W-1:0];
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      // keep the pool in step for aiming
      if (f == FUNC_INSERT) begin
         if (live_pool.size() < CAPACITY) live_pool.push_back(r.value);
      end else begin
         idx = -1;
         foreach (live_pool[i]) if (idx < 0 && live_pool[i] == r.value) idx = i;
         if (idx >= 0) live_pool.delete(idx);
      end
      send_item(r);
   endtask

   // one random item; mostly ranks near the current count so hits and
   // the first miss both show up
   task automatic random_item(input int insert_pct, input int hit_pct);
      logic        f;
      int unsigned v;
      int unsigned rk;
      int          top;
      int          pick;
      f    = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
      pick = $urandom_range(0, 99);
      if (f == FUNC_REMOVE && live_pool.size() > 0 && pick < hit_pct)
         v = live_pool[$urandom_range(0, live_pool.size() - 1)];
      else if (pick < hit_pct + (100 - hit_pct) / 2)
         v = $urandom_range(0, 15);               // small values give duplicates
      else
         v = $urandom & VALUE_MAX;
      top = (live_pool.size() > RANK_MAX) ? RANK_MAX : live_pool.size();
      if ($urandom_range(0, 3) != 0) rk = $urandom_range(0, top);
      else                           rk = $urandom_range(0, RANK_MAX);
      issue(f, v, rk);
   endtask

   initial begin
      int guard;
      sb         = new(CAPACITY);
      burst_left = 0;
      reset      = 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty store, extremes, duplicates, absent removal
      issue(FUNC_REMOVE, 5, 0);                   // remove from empty
      issue(FUNC_INSERT, VALUE_MAX, 0);           // largest value
      issue(FUNC_INSERT, 0, 1);                   // smallest value
      issue(FUNC_INSERT, 0, 0);                   // duplicate of zero
      issue(FUNC_INSERT, 32'h5555_5555, 2);
      issue(FUNC_INSERT, 32'h2aaa_aaaa, 3);
      issue(FUNC_INSERT, 1000, RANK_MAX);         // rank past the count
      issue(FUNC_REMOVE, 7, 1);                   // absent value, no change
      issue(FUNC_REMOVE, 0, 0);                   // one copy of a duplicate goes
      issue(FUNC_REMOVE, VALUE_MAX, 4);           // top element goes
      issue(FUNC_INSERT, 1000, 2);                // duplicate of a mid value
      issue(FUNC_REMOVE, 1000, 1);
      issue(FUNC_INSERT, 32'h2aaa_aaaa, 32'haa);
      issue(FUNC_REMOVE, 32'h5555_5555, 32'h55);
      issue(FUNC_INSERT, 1, 4);                   // rank equal to the count before the insert

      // mixed random traffic
      repeat (150) random_item(60, 60);

      // fill the store, then keep inserting into a full store
      guard = 0;
      while (live_pool.size() < CAPACITY && guard < 600) begin
         random_item(90, 70);
         guard++;
      end
      repeat (12) issue(FUNC_INSERT, $urandom & VALUE_MAX,
                        ($urandom_range(0, 1) == 0) ? RANK_MAX : $urandom_range(0, RANK_MAX));

      // churn around the full mark
      repeat (80) random_item(55, 80);

      // drain, mostly with removals of stored values
      guard = 0;
      while (live_pool.size() > 0 && guard < 500) begin
         random_item(10, 85);
         guard++;
      end
      issue(FUNC_REMOVE, 3, 0);                   // empty again

      start <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (sb.fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #200000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/osm_pkg.sv
rtl/osm_ctrl.sv
rtl/osm_datapath.sv
rtl/order_statistic_multiset.sv
tb/tb_order_statistic_multiset.sv
